@@ rtl/core/assert_macros.svh @@
// assertion helpers for the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked on every rising edge outside reset
`define FPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every rising edge, reset included
`define FPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/fps_pkg.sv @@
package fps_pkg;

  // field and register widths
  localparam int PIX_W     = 12;
  localparam int CLR_W     = 8;
  localparam int AFF_W     = 24;
  localparam int CTR_W     = 20;
  localparam int COEF_W    = 32;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 3;
  localparam int THETA_W   = 18;
  localparam int PHI_W     = 19;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 88;

  // datapath widths
  localparam int XY_W  = 26;
  localparam int MAG_W = 25;
  localparam int R2_W  = 52;
  localparam int RAD_W = 26;
  localparam int SUM_W = 122;
  localparam int Z_W   = 42;
  localparam int ZM_W  = 31;

  // cordic widths and depth
  localparam int CIN_W        = 32;
  localparam int NRM_W        = 59;
  localparam int CW_W         = 63;
  localparam int CZ_W         = 33;
  localparam int ANG_W        = 31;
  localparam int NRM_STEPS    = 6;
  localparam int CORDIC_ITERS = 30;
  localparam int CORDIC_LAT   = NRM_STEPS + CORDIC_ITERS;
  localparam int ISQ_LAT      = RAD_W;

  localparam int AW_W = 34;
  localparam logic [AW_W-1:0]  PI_Q30      = 34'd3373259426;
  localparam logic [ANG_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [THETA_W-1:0] THETA_MAX = 18'd205887;
  localparam logic [PHI_W-1:0]   PHI_MAX   = 19'd411775;
  localparam logic signed [Z_W-1:0] Z_LIMIT = 42'sd2147483647;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AFFINE_C    = 3'd0,
    REG_AFFINE_D    = 3'd1,
    REG_AFFINE_E    = 3'd2,
    REG_OPT_CENTER  = 3'd3,
    REG_POLY_CONST  = 3'd4,
    REG_POLY_SQUARE = 3'd5,
    REG_POLY_CUBE   = 3'd6,
    REG_POLY_FOURTH = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CLR_W-1:0] red;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] blue;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } pix_t;

  typedef struct packed {
    pix_t             pix;
    logic [MAG_W-1:0] xm;
    logic [MAG_W-1:0] ym;
    logic             x_neg;
    logic             y_neg;
    logic             z_neg;
    logic [R2_W-1:0]  r2;
    logic [RAD_W-1:0] rad;
  } side_t;

  // arctangent of 2^-i, q30
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/fps_isqrt.sv @@
module fps_isqrt
  import fps_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [R2_W-1:0]  radicand,
  output logic [RAD_W-1:0] root
);

  logic [RAD_W+1:0] rem_r   [RAD_W];
  logic [RAD_W+1:0] rem_nxt [RAD_W];
  logic [RAD_W-1:0] root_r  [RAD_W];
  logic [RAD_W-1:0] root_nxt[RAD_W];
  logic [R2_W-1:0]  n_r     [RAD_W];
  logic [R2_W-1:0]  n_nxt   [RAD_W];

  // one result bit per stage, two radicand bits consumed per stage
  always_comb begin
    logic [RAD_W+1:0] rem_in;
    logic [RAD_W-1:0] root_in;
    logic [R2_W-1:0]  n_in;
    logic [RAD_W+3:0] cur;
    logic [RAD_W+3:0] trial;
    for (int k = 0; k < RAD_W; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        n_in    = radicand;
      end else begin
        rem_in  = rem_r[(k > 0) ? k - 1 : 0];
        root_in = root_r[(k > 0) ? k - 1 : 0];
        n_in    = n_r[(k > 0) ? k - 1 : 0];
      end
      cur   = {rem_in, n_in[R2_W-1-2*k -: 2]};
      trial = {2'b00, root_in, 2'b01};
      n_nxt[k] = n_in;
      if (cur >= trial) begin
        rem_nxt[k]  = (RAD_W+2)'(cur - trial);
        root_nxt[k] = {root_in[RAD_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = (RAD_W+2)'(cur);
        root_nxt[k] = {root_in[RAD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RAD_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        n_r[k]    <= n_nxt[k];
      end
    end
  end

  assign root = root_r[RAD_W-1];

endmodule

@@ rtl/core/fps_cordic.sv @@
module fps_cordic
  import fps_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [CIN_W-1:0] x_in,
  input  logic [CIN_W-1:0] y_in,
  output logic [ANG_W-1:0] angle
);

  logic [NRM_W-1:0]       nx_r  [NRM_STEPS];
  logic [NRM_W-1:0]       ny_r  [NRM_STEPS];
  logic [NRM_W-1:0]       nx_nxt[NRM_STEPS];
  logic [NRM_W-1:0]       ny_nxt[NRM_STEPS];
  logic signed [CW_W-1:0] cx_r  [CORDIC_ITERS];
  logic signed [CW_W-1:0] cy_r  [CORDIC_ITERS];
  logic signed [CZ_W-1:0] cz_r  [CORDIC_ITERS];
  logic signed [CW_W-1:0] cx_nxt[CORDIC_ITERS];
  logic signed [CW_W-1:0] cy_nxt[CORDIC_ITERS];
  logic signed [CZ_W-1:0] cz_nxt[CORDIC_ITERS];
  logic signed [CZ_W-1:0] z_last;

  // normalize: shift by 32,16,8,4,2,1 while the top bits of both are clear
  always_comb begin
    logic [NRM_W-1:0] sx;
    logic [NRM_W-1:0] sy;
    int unsigned      sh;
    for (int k = 0; k < NRM_STEPS; k++) begin
      if (k == 0) begin
        sx = NRM_W'(x_in);
        sy = NRM_W'(y_in);
      end else begin
        sx = nx_r[(k > 0) ? k - 1 : 0];
        sy = ny_r[(k > 0) ? k - 1 : 0];
      end
      sh = 32 >> k;
      if (((sx | sy) >> (NRM_W - sh)) == '0) begin
        nx_nxt[k] = sx << sh;
        ny_nxt[k] = sy << sh;
      end else begin
        nx_nxt[k] = sx;
        ny_nxt[k] = sy;
      end
    end
  end

  // vectoring rotations, one per stage
  always_comb begin
    logic signed [CW_W-1:0] px;
    logic signed [CW_W-1:0] py;
    logic signed [CZ_W-1:0] pz;
    logic signed [CZ_W-1:0] step;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (i == 0) begin
        px = $signed(CW_W'(nx_r[NRM_STEPS-1]));
        py = $signed(CW_W'(ny_r[NRM_STEPS-1]));
        pz = '0;
      end else begin
        px = cx_r[(i > 0) ? i - 1 : 0];
        py = cy_r[(i > 0) ? i - 1 : 0];
        pz = cz_r[(i > 0) ? i - 1 : 0];
      end
      step = $signed(CZ_W'(atan_q30(i)));
      if (py > 0) begin
        cx_nxt[i] = px + (py >>> i);
        cy_nxt[i] = py - (px >>> i);
        cz_nxt[i] = pz + step;
      end else begin
        cx_nxt[i] = px - (py >>> i);
        cy_nxt[i] = py + (px >>> i);
        cz_nxt[i] = pz - step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NRM_STEPS; k++) begin
        nx_r[k] <= nx_nxt[k];
        ny_r[k] <= ny_nxt[k];
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        cx_r[i] <= cx_nxt[i];
        cy_r[i] <= cy_nxt[i];
        cz_r[i] <= cz_nxt[i];
      end
    end
  end

  // clamp to [0, pi/2]
  assign z_last = cz_r[CORDIC_ITERS-1];
  always_comb begin
    if (z_last < 0) begin
      angle = '0;
    end else if (z_last > $signed(CZ_W'(HALF_PI_Q30))) begin
      angle = HALF_PI_Q30;
    end else begin
      angle = z_last[ANG_W-1:0];
    end
  end

endmodule

@@ rtl/core/fisheye_pixel_to_sphere.sv @@
// channel  | dir | signals                        | word contents
// ---------+-----+--------------------------------+---------------------------------------
// in       | in  | in_tvalid/in_tready/in_tdata   | row, col, blue, green, red
// out      | out | out_tvalid/out_tready/out_tdata| theta, phi, row, col, blue, green, red
// cfg      | in  | cfg_we/cfg_index/cfg_wdata     | one register per write, no read-back
//
// one word per clock while the skid stage is empty; the path from input accept to
// out_tvalid runs through the 26-stage square root and the 36-stage normalize plus cordic pipeline
// rst_n is synchronous, active low; clears valid bits, output and skid state, and
// loads the register reset values (row gain 1.0, all else zero)
// the whole pipeline advances while the skid stage is empty; a stalled output word
// parks in the skid, and input is still taken after out_tready drops until one parks
// pixels outside the frame or on the optical center (zero radius) produce no word
`include "assert_macros.svh"

module fisheye_pixel_to_sphere
  import fps_pkg::*;
#(
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pixel_row, pixel_col, blue_in, green_in, red_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // polar_angle, azimuth, row_out, col_out,
                                            // blue_out, green_out, red_out, zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // stage map
  localparam int ST_AFF  = 1;                       // X, Y
  localparam int ST_SQ   = 2;                       // X^2, Y^2
  localparam int ST_R2   = 3;                       // r^2
  localparam int ST_P1   = ST_R2 + ISQ_LAT + 1;     // first polynomial stage
  localparam int ST_Z    = ST_P1 + 6;               // saturated Z
  localparam int ST_ANG  = ST_Z + CORDIC_LAT;       // raw angles
  localparam int ST_LAST = ST_ANG + 1;              // quadrant fixed, q16

  // configuration registers
  logic signed [AFF_W-1:0]  c_r, d_r, e_r;
  logic [2*CTR_W-1:0]       ctr_r;
  logic signed [COEF_W-1:0] a0_r, a2_r, a3_r, a4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r   <= 24'sd1048576;
      d_r   <= '0;
      e_r   <= '0;
      ctr_r <= '0;
      a0_r  <= '0;
      a2_r  <= '0;
      a3_r  <= '0;
      a4_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AFFINE_C:    c_r   <= cfg_wdata[AFF_W-1:0];
        REG_AFFINE_D:    d_r   <= cfg_wdata[AFF_W-1:0];
        REG_AFFINE_E:    e_r   <= cfg_wdata[AFF_W-1:0];
        REG_OPT_CENTER:  ctr_r <= cfg_wdata[2*CTR_W-1:0];
        REG_POLY_CONST:  a0_r  <= cfg_wdata[COEF_W-1:0];
        REG_POLY_SQUARE: a2_r  <= cfg_wdata[COEF_W-1:0];
        REG_POLY_CUBE:   a3_r  <= cfg_wdata[COEF_W-1:0];
        REG_POLY_FOURTH: a4_r  <= cfg_wdata[COEF_W-1:0];
      endcase
    end
  end

  // handshake and stall
  logic adv;
  logic skid_v_r, out_v_r;
  logic [OUT_DATA_W-1:0] skid_data_r, out_data_r;

  assign adv       = !skid_v_r;
  assign in_tready = adv;

  // input unpack
  pix_t in_pix;
  logic in_frame;
  assign in_pix.row   = in_tdata[11:0];
  assign in_pix.col   = in_tdata[23:12];
  assign in_pix.blue  = in_tdata[31:24];
  assign in_pix.green = in_tdata[39:32];
  assign in_pix.red   = in_tdata[47:40];
  assign in_frame = (int'(in_pix.row) < MAX_ROWS) && (int'(in_pix.col) < MAX_COLS);

  // side-band and valid shift lines
  side_t side_r  [ST_LAST+1];
  side_t side_nxt[ST_LAST+1];
  logic  valid_r  [ST_LAST+1];
  logic  valid_nxt[ST_LAST+1];

  // affine products and coordinates
  logic signed [AFF_W+PIX_W:0]   cu_r, dv_r, eu_r, cu_nxt, dv_nxt, eu_nxt;
  logic signed [AFF_W+PIX_W+1:0] cd_sum, xq, yq;
  logic signed [XY_W-1:0]        x_r, y_r, x_nxt, y_nxt;
  logic signed [2*XY_W-1:0]      xx_r, yy_r, xx_nxt, yy_nxt;
  logic [R2_W-1:0]               r2_sum;

  assign cu_nxt = c_r * $signed({1'b0, in_pix.row});
  assign dv_nxt = d_r * $signed({1'b0, in_pix.col});
  assign eu_nxt = e_r * $signed({1'b0, in_pix.row});

  // X = floor((c*u + d*v)/2^12) - u0, Y = floor(e*u/2^12) + 256*v - v0, both q8
  assign cd_sum = (AFF_W+PIX_W+2)'(cu_r) + (AFF_W+PIX_W+2)'(dv_r);
  assign xq     = cd_sum >>> 12;
  assign yq     = (AFF_W+PIX_W+2)'(eu_r) >>> 12;
  assign x_nxt  = XY_W'(xq - $signed((AFF_W+PIX_W+2)'(ctr_r[2*CTR_W-1:CTR_W])));
  assign y_nxt  = XY_W'(yq + $signed((AFF_W+PIX_W+2)'({side_r[0].pix.col, 8'h00}))
                           - $signed((AFF_W+PIX_W+2)'(ctr_r[CTR_W-1:0])));
  assign xx_nxt = x_r * x_r;
  assign yy_nxt = y_r * y_r;
  assign r2_sum = R2_W'(xx_r) + R2_W'(yy_r);

  // radius = floor(sqrt(r^2)), q8
  logic [RAD_W-1:0] isq_root;

  fps_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (side_r[ST_R2].r2),
    .root     (isq_root)
  );

  // polynomial, summed exactly at q88 with 32-bit-class partial products
  logic [RAD_W-1:0]              rh, rl;
  logic signed [COEF_W+RAD_W:0]  a2h_r, a2l_r, a2h_nxt, a2l_nxt;
  logic [2*RAD_W-1:0]            hh_r, hl_r, ll_r, hr_r, lr_r;
  logic [4*RAD_W-1:0]            sq_r;
  logic [3*RAD_W-1:0]            rr_r;
  logic signed [COEF_W+2*RAD_W:0] a2r_r, a2r3_r, a2r4_r;
  logic [4*RAD_W-17:0]           r4;
  logic signed [COEF_W+30:0]     k0_r, k1_r, k2_r, k0_nxt, k1_nxt, k2_nxt;
  logic signed [COEF_W+RAD_W:0]  q0_r, q1_r, q2_r, q0_nxt, q1_nxt, q2_nxt;
  logic signed [SUM_W-1:0]       a4t_r, a3t_r, sa_r, sb_r, sum_r;
  logic signed [Z_W-1:0]         z_full, z_sat;
  logic [ZM_W-1:0]               zm_r, zm_nxt;

  assign rh      = side_r[ST_P1-1].r2[R2_W-1:RAD_W];
  assign rl      = side_r[ST_P1-1].r2[RAD_W-1:0];
  assign a2h_nxt = a2_r * $signed({1'b0, rh});
  assign a2l_nxt = a2_r * $signed({1'b0, rl});

  assign r4     = sq_r[4*RAD_W-1:16];
  assign k0_nxt = a4_r * $signed({1'b0, r4[29:0]});
  assign k1_nxt = a4_r * $signed({1'b0, r4[59:30]});
  assign k2_nxt = a4_r * $signed({1'b0, r4[4*RAD_W-17:60]});
  assign q0_nxt = a3_r * $signed({1'b0, rr_r[RAD_W-1:0]});
  assign q1_nxt = a3_r * $signed({1'b0, rr_r[2*RAD_W-1:RAD_W]});
  assign q2_nxt = a3_r * $signed({1'b0, rr_r[3*RAD_W-1:2*RAD_W]});

  // Z = floor(sum/2^80), saturated to +-(2^31-1)
  assign z_full = Z_W'(sum_r >>> 80);
  always_comb begin
    if (z_full > Z_LIMIT) begin
      z_sat = Z_LIMIT;
    end else if (z_full < -Z_LIMIT) begin
      z_sat = -Z_LIMIT;
    end else begin
      z_sat = z_full;
    end
  end
  assign zm_nxt = z_sat[Z_W-1] ? ZM_W'(-z_sat) : ZM_W'(z_sat);

  // angle units: theta from (|Z|, radius), phi from (|X|, |Y|)
  logic [ANG_W-1:0] theta_base, phi_base;

  fps_cordic u_cordic_theta (
    .clk   (clk),
    .en    (adv),
    .x_in  (CIN_W'(zm_r)),
    .y_in  (CIN_W'(side_r[ST_Z].rad)),
    .angle (theta_base)
  );

  fps_cordic u_cordic_phi (
    .clk   (clk),
    .en    (adv),
    .x_in  (CIN_W'(side_r[ST_Z].xm)),
    .y_in  (CIN_W'(side_r[ST_Z].ym)),
    .angle (phi_base)
  );

  // quadrant resolution and rounding to q16
  function automatic logic [AW_W-15:0] to_q16(input logic [AW_W-1:0] a);
    logic [AW_W-1:0] t;
    t = a + AW_W'(8192);
    return t[AW_W-1:14];
  endfunction

  logic [AW_W-1:0]    theta_q30, phi_q30;
  logic [AW_W-15:0]   theta_q16, phi_q16;
  logic [THETA_W-1:0] polar_r, polar_nxt;
  logic [PHI_W-1:0]   az_r, az_nxt;
  side_t              qs;

  assign qs = side_r[ST_ANG];
  always_comb begin
    theta_q30 = qs.z_neg ? PI_Q30 - AW_W'(theta_base) : AW_W'(theta_base);
    priority if (!qs.x_neg && !qs.y_neg) begin
      phi_q30 = PI_Q30 + AW_W'(phi_base);
    end else if (!qs.x_neg) begin
      phi_q30 = PI_Q30 - AW_W'(phi_base);
    end else if (!qs.y_neg) begin
      phi_q30 = (PI_Q30 << 1) - AW_W'(phi_base);
    end else begin
      phi_q30 = AW_W'(phi_base);
    end
    theta_q16 = to_q16(theta_q30);
    phi_q16   = to_q16(phi_q30);
    polar_nxt = (theta_q16 > (AW_W-14)'(THETA_MAX)) ? THETA_MAX : theta_q16[THETA_W-1:0];
    az_nxt    = (phi_q16 > (AW_W-14)'(PHI_MAX)) ? PHI_MAX : phi_q16[PHI_W-1:0];
  end

  // side-band next values, with fields filled at their stages
  always_comb begin
    side_nxt[0]     = '0;
    side_nxt[0].pix = in_pix;
    valid_nxt[0]    = in_tvalid && in_frame;
    for (int k = 1; k <= ST_LAST; k++) begin
      side_nxt[k]  = side_r[k-1];
      valid_nxt[k] = valid_r[k-1];
    end
    side_nxt[ST_SQ].xm    = x_r[XY_W-1] ? MAG_W'(-x_r) : MAG_W'(x_r);
    side_nxt[ST_SQ].ym    = y_r[XY_W-1] ? MAG_W'(-y_r) : MAG_W'(y_r);
    side_nxt[ST_SQ].x_neg = x_r[XY_W-1];
    side_nxt[ST_SQ].y_neg = y_r[XY_W-1];
    side_nxt[ST_R2].r2    = r2_sum;
    valid_nxt[ST_R2]      = valid_r[ST_R2-1] && (r2_sum != '0);
    side_nxt[ST_P1].rad   = isq_root;
    side_nxt[ST_Z].z_neg  = z_sat[Z_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ST_LAST; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k <= ST_LAST; k++) begin
        valid_r[k] <= valid_nxt[k];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= ST_LAST; k++) begin
        side_r[k] <= side_nxt[k];
      end
      cu_r   <= cu_nxt;
      dv_r   <= dv_nxt;
      eu_r   <= eu_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      xx_r   <= xx_nxt;
      yy_r   <= yy_nxt;
      // P1: partial products of r^2, radius and a2
      a2h_r  <= a2h_nxt;
      a2l_r  <= a2l_nxt;
      hh_r   <= rh * rh;
      hl_r   <= rh * rl;
      ll_r   <= rl * rl;
      hr_r   <= rh * isq_root;
      lr_r   <= rl * isq_root;
      // P2: r^4, r^2*radius, a2*r^2
      sq_r   <= {hh_r, 52'h0} + (4*RAD_W)'({hl_r, 27'h0}) + (4*RAD_W)'(ll_r);
      rr_r   <= (3*RAD_W)'({hr_r, 26'h0}) + (3*RAD_W)'(lr_r);
      a2r_r  <= ((COEF_W+2*RAD_W+1)'(a2h_r) <<< RAD_W) + (COEF_W+2*RAD_W+1)'(a2l_r);
      // P3: slices times a4 and a3
      k0_r   <= k0_nxt;
      k1_r   <= k1_nxt;
      k2_r   <= k2_nxt;
      q0_r   <= q0_nxt;
      q1_r   <= q1_nxt;
      q2_r   <= q2_nxt;
      a2r3_r <= a2r_r;
      // P4: recombine
      a4t_r  <= (SUM_W'(k2_r) <<< 60) + (SUM_W'(k1_r) <<< 30) + SUM_W'(k0_r);
      a3t_r  <= (SUM_W'(q2_r) <<< 2*RAD_W) + (SUM_W'(q1_r) <<< RAD_W) + SUM_W'(q0_r);
      a2r4_r <= a2r3_r;
      // P5, P6: align to q88 and sum
      sa_r   <= (SUM_W'(a0_r) <<< 80) + (SUM_W'(a2r4_r) <<< 32);
      sb_r   <= (a3t_r <<< 8) + a4t_r;
      sum_r  <= sa_r + sb_r;
      // P7
      zm_r   <= zm_nxt;
      // last stage
      polar_r <= polar_nxt;
      az_r    <= az_nxt;
    end
  end

  // output register and skid
  logic [OUT_DATA_W-1:0] word_last;
  assign word_last = {3'b000, side_r[ST_LAST].pix.red, side_r[ST_LAST].pix.green,
                      side_r[ST_LAST].pix.blue, side_r[ST_LAST].pix.col,
                      side_r[ST_LAST].pix.row, az_r, polar_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_tready) begin
      out_v_r <= valid_r[ST_LAST];
    end else if (valid_r[ST_LAST]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_v_r || out_tready) begin
      out_data_r <= word_last;
    end else begin
      skid_data_r <= word_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  `FPS_ASSERT(a_skid_has_out, clk, rst_n, skid_v_r |-> out_v_r, "skid full with no output word")
  `FPS_ASSERT(a_skid_on_stall, clk, rst_n, $rose(skid_v_r) |-> $past(out_tvalid && !out_tready), "skid filled without stall")
  `FPS_ASSERT(a_no_zero_radius, clk, rst_n, valid_r[ST_R2] |-> (side_r[ST_R2].r2 != '0), "zero radius kept")
  `FPS_ASSERT(a_theta_range, clk, rst_n, out_tvalid |-> (out_tdata[17:0] <= THETA_MAX), "theta out of range")
  `FPS_ASSERT(a_phi_range, clk, rst_n, out_tvalid |-> (out_tdata[36:18] <= PHI_MAX), "phi out of range")

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import fps_pkg::*;

  // one expected output word, field by field
  typedef struct {
    bit [THETA_W-1:0] theta;
    bit [PHI_W-1:0]   phi;
    bit [PIX_W-1:0]   row;
    bit [PIX_W-1:0]   col;
    bit [CLR_W-1:0]   blue;
    bit [CLR_W-1:0]   green;
    bit [CLR_W-1:0]   red;
  } angle_word_t;

  // scoreboard: own copy of the registers, angle predictor, queue of expected words
  class sphere_scoreboard;
    bit [CFG_W-1:0] regs [8];
    angle_word_t    angles_due[$];
    int             errors;

    function new();
      for (int i = 0; i < 8; i++) regs[i] = '0;
      regs[REG_AFFINE_C] = 40'd1048576;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [CFG_W-1:0] val);
      if (idx == REG_OPT_CENTER) regs[idx] = val;
      else if (idx <= REG_AFFINE_E) regs[idx] = val & 40'hFF_FFFF;
      else regs[idx] = val & 40'hFFFF_FFFF;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // first-quadrant atan(y/x) in q30, vectoring cordic on normalized magnitudes
    static function longint quad_angle(longint unsigned x, longint unsigned y);
      longint xs, ys, z, dx, dy;
      longint atan_lut [30] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};
      while (x < (64'd1 << 58) && y < (64'd1 << 58)) begin
        x <<= 1;
        y <<= 1;
      end
      xs = x;
      ys = y;
      z = 0;
      for (int i = 0; i < 30; i++) begin
        dx = ys >>> i;
        dy = xs >>> i;
        if (ys > 0) begin
          xs += dx; ys -= dy; z += atan_lut[i];
        end else begin
          xs -= dx; ys += dy; z -= atan_lut[i];
        end
      end
      if (z < 0) z = 0;
      if (z > 64'd1686629713) z = 64'd1686629713;
      return z;
    endfunction

    static function longint unsigned q30_to_q16(longint a, longint unsigned lim);
      longint unsigned r;
      if (a < 0) a = 0;
      r = (a + 8192) >> 14;
      return (r > lim) ? lim : r;
    endfunction

    // accepted pixel: queue its angles unless the radius is zero
    function void note_pixel(pix_t p);
      longint c, d, e, u0, v0, u, v, x, y, a0, a2, a3, a4, z, base, theta, phi;
      longint unsigned xm, ym, r2, rad, zm;
      logic signed [127:0] acc, r2w, radw, zw;
      angle_word_t w;
      longint pi_q30;
      pi_q30 = 64'd3373259426;
      c = $signed(regs[REG_AFFINE_C][23:0]);
      d = $signed(regs[REG_AFFINE_D][23:0]);
      e = $signed(regs[REG_AFFINE_E][23:0]);
      u0 = regs[REG_OPT_CENTER][39:20];
      v0 = regs[REG_OPT_CENTER][19:0];
      a0 = $signed(regs[REG_POLY_CONST][31:0]);
      a2 = $signed(regs[REG_POLY_SQUARE][31:0]);
      a3 = $signed(regs[REG_POLY_CUBE][31:0]);
      a4 = $signed(regs[REG_POLY_FOURTH][31:0]);
      u = p.row;
      v = p.col;
      x = ((c * u + d * v) >>> 12) - u0;
      y = ((e * u) >>> 12) + (v << 8) - v0;
      xm = (x < 0) ? -x : x;
      ym = (y < 0) ? -y : y;
      r2 = xm * xm + ym * ym;
      if (r2 == 0) return;  // optical center: no word
      rad = int_sqrt(r2);
      // polynomial summed exactly at q88
      r2w = r2;
      radw = rad;
      acc = 128'(a0) <<< 80;
      acc += (128'(a2) * r2w) <<< 32;
      acc += (128'(a3) * r2w * radw) <<< 8;
      acc += 128'(a4) * ((r2w * r2w) >>> 16);
      zw = acc >>> 80;
      if (zw > 128'sd2147483647) zw = 128'sd2147483647;
      if (zw < -128'sd2147483647) zw = -128'sd2147483647;
      z = 64'(zw);
      zm = (z < 0) ? -z : z;
      base = quad_angle(zm, rad);
      theta = (z >= 0) ? base : pi_q30 - base;
      base = quad_angle(xm, ym);
      if (x >= 0) phi = (y >= 0) ? pi_q30 + base : pi_q30 - base;
      else phi = (y >= 0) ? 2 * pi_q30 - base : base;
      w.theta = q30_to_q16(theta, THETA_MAX);
      w.phi = q30_to_q16(phi, PHI_MAX);
      w.row = p.row;
      w.col = p.col;
      w.blue = p.blue;
      w.green = p.green;
      w.red = p.red;
      angles_due.insert(angles_due.size(), w);
    endfunction

    function void check_word(bit [OUT_DATA_W-1:0] dat);
      angle_word_t g, w;
      g.theta = dat[17:0];
      g.phi = dat[36:18];
      g.row = dat[48:37];
      g.col = dat[60:49];
      g.blue = dat[68:61];
      g.green = dat[76:69];
      g.red = dat[84:77];
      if (angles_due.size() == 0) begin
        $display("%0t: unexpected word %h", $time, dat);
        errors++;
        return;
      end
      w = angles_due.pop_front();
      if (g.theta !== w.theta) begin
        $display("%0t: theta exp %0d got %0d", $time, w.theta, g.theta); errors++;
      end
      if (g.phi !== w.phi) begin
        $display("%0t: phi exp %0d got %0d", $time, w.phi, g.phi); errors++;
      end
      if (g.row !== w.row) begin
        $display("%0t: row exp %0d got %0d", $time, w.row, g.row); errors++;
      end
      if (g.col !== w.col) begin
        $display("%0t: col exp %0d got %0d", $time, w.col, g.col); errors++;
      end
      if (g.blue !== w.blue) begin
        $display("%0t: blue exp %0d got %0d", $time, w.blue, g.blue); errors++;
      end
      if (g.green !== w.green) begin
        $display("%0t: green exp %0d got %0d", $time, w.green, g.green); errors++;
      end
      if (g.red !== w.red) begin
        $display("%0t: red exp %0d got %0d", $time, w.red, g.red); errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  sphere_scoreboard sb = new();
  bit calm = 1'b0;          // last part of the run: no idling on either side
  int words_seen = 0;
  int hold_left = 0;
  int gap_left = 0;
  bit held = 1'b0;

  fisheye_pixel_to_sphere dut (.*);

  always #6 clk = ~clk;

  // receiver: checks accepted words, random stall bursts, one long hold-off
  always @(posedge clk) begin
    if (out_tvalid === 1'b1 && out_tready) begin
      sb.check_word(out_tdata);
      words_seen++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!held && words_seen >= 500) begin
      // long hold-off so the pipeline fills and in_tready drops
      held = 1'b1;
      hold_left = 399;
      out_tready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_tready <= 1'b0;
    end else if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
      gap_left = $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // offer one pixel, possibly after an idle burst, and wait for the handshake
  task automatic push_pixel(pix_t p);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(p);
  endtask

  task automatic push_rc(int r, int c, bit [7:0] b, bit [7:0] g, bit [7:0] rd);
    pix_t p;
    p.row = r;
    p.col = c;
    p.blue = b;
    p.green = g;
    p.red = rd;
    push_pixel(p);
  endtask

  // stop sending until every word is back, then let zero-radius pixels drain
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.angles_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // load all eight registers, one write per clock
  task automatic load_regs(bit [CFG_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_reg_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // random register value: extremes, full range or a scaled-down value
  function automatic bit [CFG_W-1:0] pick_reg(int w, bit is_signed);
    bit [CFG_W-1:0] v;
    bit [CFG_W-1:0] mask;
    mask = (40'd1 << w) - 1;
    if (w == 40) mask = '1;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: v = is_signed ? (40'd1 << (w - 1)) : '0;
      1: v = is_signed ? ((40'd1 << (w - 1)) - 1) : mask;
      2: ;
      default: begin
        v = v & mask;
        if (is_signed && v[w-1]) v = ~((~v & mask) >> $urandom_range(0, w - 2));
        else v = v >> $urandom_range(0, w - 1);
      end
    endcase
    return v & mask;
  endfunction

  initial begin
    #(12 * 400000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    bit [CFG_W-1:0] vals [8];
    pix_t p;
    int n_items;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: x = 256*row, y = 256*col
    push_rc(0, 0, 8'h00, 8'h00, 8'h00);        // zero radius, no word
    push_rc(4095, 4095, 8'hFF, 8'hFF, 8'hFF);
    push_rc(0, 4095, 8'hAA, 8'h55, 8'h0F);
    push_rc(4095, 0, 8'h55, 8'hAA, 8'hF0);
    push_rc(1, 0, 8'h01, 8'h80, 8'hFE);
    push_rc(0, 1, 8'h80, 8'h01, 8'h7F);
    push_rc(2730, 1365, 8'h12, 8'h34, 8'h56);
    drain();

    // all gains and coefficients at their maximum: z saturates high
    vals = '{40'h7F_FFFF, 40'h7F_FFFF, 40'h7F_FFFF, 40'h0,
             40'h7FFF_FFFF, 40'h7FFF_FFFF, 40'h7FFF_FFFF, 40'h7FFF_FFFF};
    load_regs(vals);
    push_rc(4095, 4095, 8'hFF, 8'h00, 8'hFF);
    push_rc(2048, 1, 8'h00, 8'hFF, 8'h00);
    push_rc(0, 0, 8'h3C, 8'hC3, 8'h99);         // zero radius again
    drain();

    // all at their minimum, center at its top: z saturates low
    vals = '{40'h80_0000, 40'h80_0000, 40'h80_0000, 40'hFF_FFFF_FFFF,
             40'h8000_0000, 40'h8000_0000, 40'h8000_0000, 40'h8000_0000};
    load_regs(vals);
    push_rc(4095, 4095, 8'h11, 8'h22, 8'h33);
    push_rc(0, 0, 8'h44, 8'h55, 8'h66);
    push_rc(4095, 0, 8'h77, 8'h88, 8'h99);
    drain();

    // y = 0 with negative x on the axis, azimuth at 2pi; huge positive z
    vals = '{40'd1048576, 40'h0, 40'h0, 40'd100000 << 20,
             40'h7FFF_FFFF, 40'h0, 40'h0, 40'h0};
    load_regs(vals);
    push_rc(0, 0, 8'hDE, 8'hAD, 8'hBE);
    push_rc(10, 0, 8'hEF, 8'h01, 8'h23);
    push_rc(390, 0, 8'h45, 8'h67, 8'h89);      // x just short of the center, still negative
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      vals[0] = pick_reg(24, 1);
      vals[1] = pick_reg(24, 1);
      vals[2] = pick_reg(24, 1);
      vals[3] = pick_reg(40, 0);
      for (int i = 4; i < 8; i++) vals[i] = pick_reg(32, 1);
      if (ph == 0) vals = '{40'd1048576, 40'h0, 40'h0, {20'd524288, 20'd524288},
                            40'd300000, -40'd2000 & 40'hFFFF_FFFF, 40'h0, 40'h0};
      if (ph == 6) calm = 1'b1;
      load_regs(vals);
      n_items = (ph == 0) ? 700 : 180;
      for (int k = 0; k < n_items; k++) begin
        p = {$urandom, $urandom};
        if ($urandom_range(0, 31) == 0) begin
          // land exactly on the optical center when the center allows it
          p.row = vals[3][39:28];
          p.col = vals[3][19:8];
        end
        push_pixel(p);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
